[rtl/core/rgfv_pkg.sv]
// Shared widths, sine polynomial constants, register codes and types for the fan vertex block.
package rgfv_pkg;

   localparam int FILL_W      = 18;
   localparam int FRAC_W      = 17;
   localparam int ONE_Q16     = 65536;
   localparam int Q16_SH      = 16;
   localparam int IDX_W       = 6;
   localparam int POS_W       = 19;
   localparam int TEX_W       = 17;
   localparam int RAD_W       = 12;
   localparam int OFF_W       = 14;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 14;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 80;

   localparam int MAG_W       = 31;
   localparam int FRAC_SH     = 30;
   localparam int LANE_DEPTH  = 7;
   localparam int POS_SH      = 26;
   localparam int TEX_SH      = 15;
   localparam int TEX_PRE_W   = 32;

   typedef logic [MAG_W-1:0] mag_type;

   localparam mag_type Q30 = mag_type'(1073741824);
   localparam mag_type C1  = mag_type'(1686629713);
   localparam mag_type C3  = mag_type'(693598668);
   localparam mag_type C5  = mag_type'(85569306);
   localparam mag_type C7  = mag_type'(5026995);
   localparam mag_type C9  = mag_type'(172272);
   localparam mag_type C11 = mag_type'(3864);

   localparam mag_type HORNER_COEF [4] = '{C9, C7, C5, C3};

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_RADIUS   = csr_idx_type'(0);
   localparam csr_idx_type REG_OFFSET_X = csr_idx_type'(1);
   localparam csr_idx_type REG_OFFSET_Y = csr_idx_type'(2);
   localparam csr_idx_type REG_REVERSE  = csr_idx_type'(3);

   typedef struct packed {
      logic             centre;
      logic             last;
      logic [IDX_W-1:0] idx;
   } tag_type;

endpackage

[rtl/core/rgfv_sin_lane.sv]
// Pipelined quarter-wave sine polynomial, Horner form in Q30, one stage per product.
module rgfv_sin_lane (
   input  logic            clock,
   input  logic            advance,
   input  rgfv_pkg::mag_type x_in,
   output rgfv_pkg::mag_type mag_out
);
   import rgfv_pkg::*;

   function automatic mag_type mul_q30(input mag_type a, input mag_type b);
      logic [2*MAG_W-1:0] p;
      p = {{MAG_W{1'b0}}, a} * {{MAG_W{1'b0}}, b};
      return p[FRAC_SH +: MAG_W];
   endfunction

   mag_type x_ff  [LANE_DEPTH-1];
   mag_type xx_ff [LANE_DEPTH-2];
   mag_type t_ff  [1:LANE_DEPTH-1];
   mag_type t_in  [1:LANE_DEPTH-1];
   mag_type xx_in;

   always_comb begin
      xx_in = mul_q30(x_in, x_in);
      t_in[1] = mul_q30(C11, xx_ff[0]);
      for (int k = 2; k < LANE_DEPTH-1; k++) begin
         t_in[k] = mul_q30(HORNER_COEF[k-2] - t_ff[k-1], xx_ff[k-1]);
      end
      t_in[LANE_DEPTH-1] = mul_q30(C1 - t_ff[LANE_DEPTH-2], x_ff[LANE_DEPTH-2]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]  <= x_in;
         xx_ff[0] <= xx_in;
         for (int k = 1; k < LANE_DEPTH-1; k++) begin
            x_ff[k] <= x_ff[k-1];
         end
         for (int k = 1; k < LANE_DEPTH-2; k++) begin
            xx_ff[k] <= xx_ff[k-1];
         end
         for (int k = 1; k < LANE_DEPTH; k++) begin
            t_ff[k] <= t_in[k];
         end
      end
   end

   assign mag_out = (t_ff[LANE_DEPTH-1] > Q30) ? Q30 : t_ff[LANE_DEPTH-1];

endmodule

[rtl/core/radial_gauge_fan_vertices.sv]
// Radial gauge triangle-fan vertex generator: sequencer, angle, sine lanes and position stages.
// Throughput: RESOLUTION+2 vertex words per request, set by the vertex sequencer,
// one per cycle while rsp does not stall.
// The next request is taken in the cycle the sequencer issues the final rim vertex.
// A stall on rsp holds every stage; nothing is dropped or repeated.
// Reset clears all valid bits and the sequencer and loads radius 100, offsets 0, reverse 0.
module radial_gauge_fan_vertices #(
   parameter int RESOLUTION = 60,
   parameter int ANGLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rgfv_pkg::REQ_DATA_W-1:0]   req_tdata,   // [17:0] fill_fraction
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rgfv_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [5:0] vertex_index, [24:6] vertex_x,
                                                          // [43:25] vertex_y, [60:44] tex_u,
                                                          // [77:61] tex_v
   output logic                              rsp_tlast,   // last_vertex
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rgfv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rgfv_pkg::CSR_DATA_W-1:0]   csr_data
);
   import rgfv_pkg::*;

   localparam int PW = $clog2(ONE_Q16 * RESOLUTION + 1);
   localparam int NW = PW + ANGLE_BITS + 1;
   localparam int MW = NW - Q16_SH;
   localparam int SH = MW + $clog2(RESOLUTION);
   localparam longint unsigned RECIP_L =
      ((longint'(1) << SH) + longint'(RESOLUTION) - 1) / longint'(RESOLUTION);
   localparam logic [SH-1:0] RECIP = SH'(RECIP_L);
   localparam logic [ANGLE_BITS-1:0] BASE    = ANGLE_BITS'(3 << (ANGLE_BITS-2));
   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS-2));
   localparam logic [IDX_W-1:0] LAST_CODE = IDX_W'(RESOLUTION + 1);
   localparam int PRW = RAD_W + MAG_W;
   localparam int PMW = PRW - POS_SH;
   localparam int PAD_W = RSP_DATA_W - (IDX_W + 2*POS_W + 2*TEX_W);

   function automatic mag_type fold_angle(input logic [ANGLE_BITS-1:0] a);
      mag_type r;
      r = {1'b0, a[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
      return a[ANGLE_BITS-2] ? (Q30 - r) : r;
   endfunction

   // configuration registers
   logic [RAD_W-1:0] radius_ff;
   logic [OFF_W-1:0] offset_x_ff, offset_y_ff;
   logic             reverse_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= RAD_W'(100);
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         reverse_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RADIUS:   radius_ff   <= csr_data[RAD_W-1:0];
            REG_OFFSET_X: offset_x_ff <= csr_data[OFF_W-1:0];
            REG_OFFSET_Y: offset_y_ff <= csr_data[OFF_W-1:0];
            REG_REVERSE:  reverse_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // sequencer
   logic              advance, issue, accept;
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [PW-1:0]     acc_ff, acc_in;
   logic [FRAC_W-1:0] fill_ff, fill_in, fill_clamp;
   logic [FILL_W-1:0] fill_raw;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign issue      = advance && busy_ff;
   assign req_tready = advance && (!busy_ff || idx_ff == LAST_CODE);
   assign accept     = req_tvalid && req_tready;
   assign fill_raw   = req_tdata[FILL_W-1:0];

   always_comb begin
      if (fill_raw[FILL_W-1]) begin
         fill_clamp = '0;
      end else if (fill_raw[FILL_W-2:0] > (FILL_W-1)'(ONE_Q16)) begin
         fill_clamp = FRAC_W'(ONE_Q16);
      end else begin
         fill_clamp = fill_raw[FRAC_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      fill_in = fill_ff;
      if (issue) begin
         idx_in = idx_ff + IDX_W'(1);
         if (idx_ff != '0) begin
            acc_in = acc_ff + PW'(fill_ff);
         end
         if (idx_ff == LAST_CODE) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in = 1'b1;
         idx_in  = '0;
         acc_in  = '0;
         fill_in = fill_clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      acc_ff  <= acc_in;
      fill_ff <= fill_in;
   end

   // stage 1: scaled phase numerator
   logic          s1_valid_ff;
   tag_type       s1_tag_ff, s1_tag_in;
   logic [MW-1:0] s1_m_ff;
   logic [NW-1:0] nsum;

   assign nsum = (NW'(acc_ff) << ANGLE_BITS) + (NW'(RESOLUTION) << (Q16_SH-1));
   assign s1_tag_in = '{centre: (idx_ff == '0), last: (idx_ff == LAST_CODE), idx: idx_ff};

   // stage 2: divide by RESOLUTION through the reciprocal
   logic             s2_valid_ff;
   tag_type          s2_tag_ff;
   logic [MW+SH-1:0] s2_prod_ff;

   // stage 3: angle and quarter-wave fold
   logic                  s3_valid_ff;
   tag_type               s3_tag_ff;
   mag_type               s3_xs_ff, s3_xc_ff;
   logic [1:0]            s3_neg_ff;
   logic [ANGLE_BITS-1:0] phase, ang_s, ang_c;

   assign phase = s2_prod_ff[SH +: ANGLE_BITS];
   assign ang_s = reverse_ff ? (BASE - phase) : (BASE + phase);
   assign ang_c = ang_s + QUARTER;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s1_tag_ff  <= s1_tag_in;
         s1_m_ff    <= nsum[NW-1:Q16_SH];
         s2_tag_ff  <= s1_tag_ff;
         s2_prod_ff <= (MW+SH)'(s1_m_ff) * (MW+SH)'(RECIP);
         s3_tag_ff  <= s2_tag_ff;
         s3_xs_ff   <= fold_angle(ang_s);
         s3_xc_ff   <= fold_angle(ang_c);
         s3_neg_ff  <= {ang_c[ANGLE_BITS-1], ang_s[ANGLE_BITS-1]};
      end
   end

   // sine and cosine lanes with aligned side information
   mag_type    mag_s, mag_c;
   logic       dly_valid_ff [LANE_DEPTH];
   tag_type    dly_tag_ff   [LANE_DEPTH];
   logic [1:0] dly_neg_ff   [LANE_DEPTH];

   rgfv_sin_lane u_sin_lane (
      .clock   (clock),
      .advance (advance),
      .x_in    (s3_xs_ff),
      .mag_out (mag_s)
   );

   rgfv_sin_lane u_cos_lane (
      .clock   (clock),
      .advance (advance),
      .x_in    (s3_xc_ff),
      .mag_out (mag_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LANE_DEPTH; k++) begin
            dly_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         dly_valid_ff[0] <= s3_valid_ff;
         for (int k = 1; k < LANE_DEPTH; k++) begin
            dly_valid_ff[k] <= dly_valid_ff[k-1];
         end
      end
      if (advance) begin
         dly_tag_ff[0] <= s3_tag_ff;
         dly_neg_ff[0] <= s3_neg_ff;
         for (int k = 1; k < LANE_DEPTH; k++) begin
            dly_tag_ff[k] <= dly_tag_ff[k-1];
            dly_neg_ff[k] <= dly_neg_ff[k-1];
         end
      end
   end

   // stage 4: radius products and texture sums
   logic                 s4_valid_ff;
   tag_type              s4_tag_ff;
   logic [1:0]           s4_neg_ff;
   logic [PRW-1:0]       s4_rx_ff, s4_ry_ff;
   logic [TEX_PRE_W-1:0] s4_u_ff, s4_v_ff;
   mag_type              ms_eff, mc_eff;
   tag_type              lane_tag;
   logic [1:0]           lane_neg;

   assign lane_tag = dly_tag_ff[LANE_DEPTH-1];
   assign lane_neg = dly_neg_ff[LANE_DEPTH-1];
   assign ms_eff   = lane_tag.centre ? '0 : mag_s;
   assign mc_eff   = lane_tag.centre ? '0 : mag_c;

   // stage 5: output word
   logic                  rsp_valid_ff;
   logic [IDX_W-1:0]      rsp_idx_ff;
   logic [POS_W-1:0]      rsp_x_ff, rsp_y_ff;
   logic [TEX_W-1:0]      rsp_u_ff, rsp_v_ff;
   logic                  rsp_last_ff;
   logic [PRW-1:0]        rsum_x, rsum_y;
   logic [PMW-1:0]        pmag_x, pmag_y;
   logic signed [OFF_W:0] base_x, base_y;
   logic [POS_W:0]        bx, by, dx, dy, x_sum, y_sum;
   logic [TEX_PRE_W-1:0]  usum, vsum;

   assign rsum_x = s4_rx_ff + (PRW'(1) << (POS_SH-1));
   assign rsum_y = s4_ry_ff + (PRW'(1) << (POS_SH-1));
   assign pmag_x = rsum_x[PRW-1:POS_SH];
   assign pmag_y = rsum_y[PRW-1:POS_SH];
   assign base_x = $signed({{(OFF_W+1-RAD_W){1'b0}}, radius_ff})
                 + $signed({offset_x_ff[OFF_W-1], offset_x_ff});
   assign base_y = $signed({{(OFF_W+1-RAD_W){1'b0}}, radius_ff})
                 + $signed({offset_y_ff[OFF_W-1], offset_y_ff});
   assign bx     = {(POS_W+1-4)'(base_x), 4'b0000};
   assign by     = {(POS_W+1-4)'(base_y), 4'b0000};
   assign dx     = s4_neg_ff[1] ? -((POS_W+1)'(pmag_x)) : (POS_W+1)'(pmag_x);
   assign dy     = s4_neg_ff[0] ? -((POS_W+1)'(pmag_y)) : (POS_W+1)'(pmag_y);
   assign x_sum  = bx + dx;
   assign y_sum  = by + dy;
   assign usum   = s4_u_ff + (TEX_PRE_W'(1) << (TEX_SH-1));
   assign vsum   = s4_v_ff + (TEX_PRE_W'(1) << (TEX_SH-1));

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff  <= dly_valid_ff[LANE_DEPTH-1];
         rsp_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s4_tag_ff   <= lane_tag;
         s4_neg_ff   <= lane_neg;
         s4_rx_ff    <= PRW'(radius_ff) * PRW'(mc_eff);
         s4_ry_ff    <= PRW'(radius_ff) * PRW'(ms_eff);
         s4_u_ff     <= lane_neg[1] ? (TEX_PRE_W'(Q30) - TEX_PRE_W'(mc_eff))
                                    : (TEX_PRE_W'(Q30) + TEX_PRE_W'(mc_eff));
         s4_v_ff     <= lane_neg[0] ? (TEX_PRE_W'(Q30) - TEX_PRE_W'(ms_eff))
                                    : (TEX_PRE_W'(Q30) + TEX_PRE_W'(ms_eff));
         rsp_idx_ff  <= s4_tag_ff.idx;
         rsp_last_ff <= s4_tag_ff.last;
         rsp_x_ff    <= x_sum[POS_W-1:0];
         rsp_y_ff    <= y_sum[POS_W-1:0];
         rsp_u_ff    <= usum[TEX_PRE_W-1:TEX_SH];
         rsp_v_ff    <= vsum[TEX_PRE_W-1:TEX_SH];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_v_ff, rsp_u_ff, rsp_y_ff, rsp_x_ff, rsp_idx_ff};

endmodule

[rtl/core/rgfv_checker.sv]
// Port-level checks on the fan vertex output stream, bound to the top level.
module rgfv_checker #(
   parameter int RESOLUTION = 60
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rgfv_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import rgfv_pkg::*;

   localparam logic [IDX_W-1:0] LAST_CODE = IDX_W'(RESOLUTION + 1);

   logic             rsp_word;
   logic [IDX_W-1:0] rsp_idx;

   assign rsp_word = rsp_tvalid && rsp_tready;
   assign rsp_idx  = rsp_tdata[IDX_W-1:0];

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp word changed");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_word && !rsp_tlast |=> rsp_tvalid && rsp_idx == IDX_W'($past(rsp_idx) + IDX_W'(1)))
      else $error("vertex index did not advance by one");

   a_restart_at_centre: assert property (@(posedge clock) disable iff (reset)
      rsp_word && rsp_tlast |=> !rsp_tvalid || rsp_idx == '0)
      else $error("next fan did not start at the centre vertex");

   a_last_matches_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_idx == LAST_CODE)))
      else $error("tlast does not match the final rim index");

endmodule

bind radial_gauge_fan_vertices rgfv_checker #(.RESOLUTION(RESOLUTION)) u_rgfv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[sim/tb_radial_gauge_fan_vertices.sv]
// Self-checking testbench for the radial gauge fan vertex generator, with a vertex predictor.
module tb_radial_gauge_fan_vertices;
   timeunit 1ns;
   timeprecision 1ps;

   import rgfv_pkg::*;

   localparam int FAN_STEPS   = 60;
   localparam int ANGLE_W     = 16;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 24;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 54;

   localparam longint unsigned ONE30 = 64'd1073741824;
   localparam longint unsigned K1    = 64'd1686629713;
   localparam longint unsigned K3    = 64'd693598668;
   localparam longint unsigned K5    = 64'd85569306;
   localparam longint unsigned K7    = 64'd5026995;
   localparam longint unsigned K9    = 64'd172272;
   localparam longint unsigned K11   = 64'd3864;
   localparam longint          ARC_DEN  = longint'(FAN_STEPS) * 65536;
   localparam longint          ANG_BASE = (longint'(3) << ANGLE_W) >> 2;

   typedef struct {
      logic [IDX_W-1:0] idx;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [TEX_W-1:0] u;
      logic [TEX_W-1:0] v;
      logic             last;
   } vertex_type;

   class fan_scoreboard;
      logic [RAD_W-1:0]        radius;
      logic signed [OFF_W-1:0] off_x;
      logic signed [OFF_W-1:0] off_y;
      logic                    rev;
      vertex_type              vertex_q[$];
      int                      errors;
      int                      checked;

      function new();
         radius  = RAD_W'(100);
         off_x   = '0;
         off_y   = '0;
         rev     = 1'b0;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            REG_RADIUS:   radius = d[RAD_W-1:0];
            REG_OFFSET_X: off_x  = d[OFF_W-1:0];
            REG_OFFSET_Y: off_y  = d[OFF_W-1:0];
            REG_REVERSE:  rev    = d[0];
            default:      ;
         endcase
      endfunction

      // sin(pi/2 * x), x and result in Q30
      function longint unsigned quarter_wave(longint unsigned x);
         longint unsigned x2;
         longint unsigned p;
         x2 = (x * x) >> 30;
         p  = K11;
         p  = K9 - ((p * x2) >> 30);
         p  = K7 - ((p * x2) >> 30);
         p  = K5 - ((p * x2) >> 30);
         p  = K3 - ((p * x2) >> 30);
         p  = K1 - ((p * x2) >> 30);
         p  = (p * x) >> 30;
         return (p > ONE30) ? ONE30 : p;
      endfunction

      function longint sine_q30(logic [31:0] a);
         longint unsigned r;
         longint unsigned m;
         r = longint'(a[29:0]);
         m = a[30] ? quarter_wave(ONE30 - r) : quarter_wave(r);
         return a[31] ? -longint'(m) : longint'(m);
      endfunction

      function longint round_off(longint p, int sh);
         longint unsigned mag;
         mag = (p < 0) ? longint'(-p) : p;
         mag = (mag + (64'd1 << (sh - 1))) >> sh;
         return (p < 0) ? -longint'(mag) : longint'(mag);
      endfunction

      function void note_request(logic [FILL_W-1:0] raw);
         longint                f;
         longint                fill;
         longint                r;
         longint                bx;
         longint                by;
         longint                ph;
         longint                c30;
         longint                s30;
         longint                px;
         longint                py;
         longint                tu;
         longint                tv;
         logic [ANGLE_W-1:0]    ang;
         logic [31:0]           a32;
         vertex_type            vx;
         f    = $signed(raw);
         fill = (f < 0) ? 0 : (f > 65536) ? 65536 : f;
         r    = longint'(radius);
         bx   = 16 * (r + longint'(off_x));
         by   = 16 * (r + longint'(off_y));
         vx.idx  = '0;
         vx.x    = bx[POS_W-1:0];
         vx.y    = by[POS_W-1:0];
         vx.u    = TEX_W'(32768);
         vx.v    = TEX_W'(32768);
         vx.last = 1'b0;
         vertex_q.push_back(vx);
         for (int i = 0; i <= FAN_STEPS; i++) begin
            ph  = (((fill * i) << ANGLE_W) + ARC_DEN / 2) / ARC_DEN;
            ang = rev ? ANGLE_W'(ANG_BASE - ph) : ANGLE_W'(ANG_BASE + ph);
            a32 = 32'(ang) << (32 - ANGLE_W);
            s30 = sine_q30(a32);
            c30 = sine_q30(a32 + 32'h4000_0000);
            px  = bx + round_off(r * c30, 26);
            py  = by + round_off(r * s30, 26);
            tu  = round_off(longint'(ONE30) + c30, 15);
            tv  = round_off(longint'(ONE30) + s30, 15);
            vx.idx  = IDX_W'(i + 1);
            vx.x    = px[POS_W-1:0];
            vx.y    = py[POS_W-1:0];
            vx.u    = tu[TEX_W-1:0];
            vx.v    = tv[TEX_W-1:0];
            vx.last = (i == FAN_STEPS);
            vertex_q.push_back(vx);
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (act !== exp) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            errors++;
         end
      endfunction

      function void check_vertex(logic [RSP_DATA_W-1:0] d, logic tl);
         vertex_type e;
         if (vertex_q.size() == 0) begin
            $error("vertex word with nothing outstanding: data %h last %b", d, tl);
            errors++;
            return;
         end
         e = vertex_q.pop_front();
         checked++;
         compare_field("vertex_index", 32'(e.idx), 32'(d[5:0]));
         compare_field("vertex_x", 32'(e.x), 32'(d[24:6]));
         compare_field("vertex_y", 32'(e.y), 32'(d[43:25]));
         compare_field("tex_u", 32'(e.u), 32'(d[60:44]));
         compare_field("tex_v", 32'(e.v), 32'(d[77:61]));
         compare_field("last_vertex", 32'(e.last), 32'(tl));
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;   // [17:0] fill_fraction
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;   // [5:0] vertex_index, [24:6] vertex_x, [43:25] vertex_y,
                                         // [60:44] tex_u, [77:61] tex_v
   logic                    rsp_tlast;   // last_vertex
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   fan_scoreboard sb = new();
   bit            hold_rsp = 1'b0;
   int            cycle_count = 0;
   int            n_requests = 0;
   int            n_settings = 0;

   radial_gauge_fan_vertices #(
      .RESOLUTION (FAN_STEPS),
      .ANGLE_BITS (ANGLE_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("radial_gauge_fan_vertices: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         sb.check_vertex(rsp_tdata, rsp_tlast);
      end
   end

   // receiver: stall on a changing pattern, with one long hold-off on request
   initial begin
      int mode;
      int left;
      int tick;
      mode = 0;
      left = 0;
      tick = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 300);
         end
         left--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            2:       rsp_tready <= ((tick % 7) < 4);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   task automatic push_fill(input logic [FILL_W-1:0] f);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(f);
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(f);
      n_requests++;
   endtask

   task automatic pause_sender(input int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.vertex_q.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_reg(idx, d);
   endtask

   task automatic program_gauge(input logic [RAD_W-1:0] r, input logic [OFF_W-1:0] ox,
                                input logic [OFF_W-1:0] oy, input logic rv, input bit poke);
      if (poke) begin
         write_reg(csr_idx_type'($urandom_range(int'(REG_REVERSE) + 1, 2**CSR_IDX_W - 1)),
                   CSR_DATA_W'($urandom_range(0, 2**CSR_DATA_W - 1)));
      end
      write_reg(REG_RADIUS, CSR_DATA_W'(r));
      write_reg(REG_OFFSET_X, CSR_DATA_W'(ox));
      write_reg(REG_OFFSET_Y, CSR_DATA_W'(oy));
      write_reg(REG_REVERSE, CSR_DATA_W'(rv));
      csr_valid <= 1'b0;
      @(posedge clock);
      n_settings++;
   endtask

   function automatic logic [FILL_W-1:0] pick_fill();
      case ($urandom_range(0, 9))
         7:       return FILL_W'(-$urandom_range(1, 131072));
         8:       return FILL_W'($urandom_range(65537, 131071));
         9:       return $urandom_range(0, 1) ? FILL_W'(65536) : FILL_W'(0);
         default: return FILL_W'($urandom_range(0, 65536));
      endcase
   endfunction

   initial begin
      logic [RAD_W-1:0] r;
      logic [OFF_W-1:0] ox;
      logic [OFF_W-1:0] oy;
      int               sent;
      int               burst;
      int               gap_style;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: clamp edges, zero fill, full turn
      push_fill(FILL_W'(0));
      push_fill(FILL_W'(65536));
      push_fill(FILL_W'(32768));
      push_fill(FILL_W'(-1));
      push_fill(FILL_W'(-131072));
      push_fill(FILL_W'(131071));
      push_fill(FILL_W'(65537));
      push_fill(FILL_W'(1));
      push_fill(FILL_W'(65535));
      drain();

      program_gauge(RAD_W'(4095), OFF_W'(8191), OFF_W'(8191), 1'b0, 1'b0);
      push_fill(FILL_W'(65536));
      push_fill(FILL_W'(21845));
      drain();

      program_gauge(RAD_W'(4095), OFF_W'(-8192), OFF_W'(-8192), 1'b1, 1'b0);
      push_fill(FILL_W'(65536));
      push_fill(FILL_W'(49152));
      push_fill(FILL_W'(0));
      drain();

      program_gauge(RAD_W'(0), OFF_W'(8191), OFF_W'(-8192), 1'b1, 1'b1);
      push_fill(FILL_W'(65536));
      push_fill(FILL_W'(12345));
      drain();

      program_gauge(RAD_W'(1), OFF_W'(0), OFF_W'(0), 1'b0, 1'b1);
      push_fill(FILL_W'(65536));
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case ($urandom_range(0, 4))
            0:       r = '0;
            1:       r = '1;
            default: r = RAD_W'($urandom_range(1, 4094));
         endcase
         case ($urandom_range(0, 4))
            0:       ox = OFF_W'(-8192);
            1:       ox = OFF_W'(8191);
            default: ox = OFF_W'($urandom_range(0, 16383));
         endcase
         case ($urandom_range(0, 4))
            0:       oy = OFF_W'(-8192);
            1:       oy = OFF_W'(8191);
            default: oy = OFF_W'($urandom_range(0, 16383));
         endcase
         program_gauge(r, ox, oy, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
         gap_style = ph % 3;
         sent = 0;
         if (ph == 2) begin
            // hold the receiver and keep offering until the block backs up
            hold_rsp = 1'b1;
            repeat (12) push_fill(pick_fill());
            sent = 12;
         end
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
               push_fill(pick_fill());
               sent++;
            end
            if (ph == 5 && sent >= PHASE_ITEMS / 2 && sent - burst < PHASE_ITEMS / 2) begin
               drain();
            end else if (gap_style == 1) begin
               pause_sender($urandom_range(0, 6));
            end else if (gap_style == 2) begin
               pause_sender($urandom_range(0, 120));
            end
         end
         drain();
      end

      $display("fill requests: %0d over %0d register settings, vertex words checked: %0d",
               n_requests, n_settings + 1, sb.checked);
      $display("clamp edges, zero and full fill, both sweeps, radius and offset extremes covered");
      if (sb.errors == 0 && sb.vertex_q.size() == 0) begin
         $display("radial_gauge_fan_vertices: match");
      end else begin
         $display("radial_gauge_fan_vertices: mismatch");
      end
      $finish;
   end

endmodule
